// ----- design/prfd_pkg.sv -----
// Package: shared types and codes for the pulse ratio frame decoder.
package prfd_pkg;

	typedef enum logic [1:0] {
		STATUS_CONTINUE = 2'd0,
		STATUS_RESTART  = 2'd1,
		STATUS_DONE     = 2'd2
	} status_t;

	typedef enum logic {
		REG_FRAME_BYTES    = 1'b0,
		REG_PREAMBLE_RATIO = 1'b1
	} reg_idx_t;

	localparam logic [4:0] FRAME_BYTES_RST    = 5'd2;
	localparam logic [7:0] PREAMBLE_RATIO_RST = 8'd25;

	typedef struct packed {
		logic [4:0] frame_bytes;
		logic [7:0] preamble_ratio;
	} cfg_t;

	typedef struct packed {
		logic [3:0] byte_index;
		logic [7:0] byte_value;
		logic       byte_valid;
		logic       bit_value;
		logic       bit_valid;
		status_t    status;
	} result_t;

endpackage

// ----- design/prfd_cfg.sv -----
// Configuration registers behind the APB-style port.
module prfd_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output prfd_pkg::cfg_t      cfg
);

	logic [4:0]         frame_bytes_q;
	logic [7:0]         preamble_ratio_q;
	prfd_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = prfd_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bytes_q    <= prfd_pkg::FRAME_BYTES_RST;
			preamble_ratio_q <= prfd_pkg::PREAMBLE_RATIO_RST;
		end else if (wr_en) begin
			unique case (idx)
				prfd_pkg::REG_FRAME_BYTES:    frame_bytes_q    <= pwdata[4:0];
				prfd_pkg::REG_PREAMBLE_RATIO: preamble_ratio_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			prfd_pkg::REG_FRAME_BYTES:    prdata = {27'd0, frame_bytes_q};
			prfd_pkg::REG_PREAMBLE_RATIO: prdata = {24'd0, preamble_ratio_q};
			default:                      prdata = 32'd0;
		endcase
	end

	assign cfg.frame_bytes    = frame_bytes_q;
	assign cfg.preamble_ratio = preamble_ratio_q;

endmodule

// ----- design/prfd_core.sv -----
// Input register, decoder state and the single-pass pulse decode.
module prfd_core #(
	parameter int MAX_FRAME_BYTES = 16,
	parameter int DURATION_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_take,
	input  logic                in_level,
	input  logic [15:0]         in_duration,
	input  logic                adv,
	input  prfd_pkg::cfg_t      cfg,
	output logic                valid_s1,
	output prfd_pkg::result_t   res
);

	localparam int DW = (DURATION_BITS < 16) ? DURATION_BITS : 16;
	localparam int CW = $clog2(MAX_FRAME_BYTES * 8 + 1);
	localparam int W2 = DW + 2;
	localparam int W4 = DW + 4;
	localparam int PW = DW + 9;
	localparam logic [4:0] MAX_FB = 5'(MAX_FRAME_BYTES);

	logic          level_s1;
	logic [DW-1:0] dur_s1;

	logic          locked_q;
	logic [DW-1:0] last_q;
	logic [CW-1:0] bit_count_q;
	logic [7:0]    byte_shift_q;

	logic          locked_n;
	logic [DW-1:0] last_n;
	logic [CW-1:0] bit_count_n;
	logic [7:0]    byte_shift_n;

	logic [4:0]    frame_len;
	logic [CW-1:0] total;
	logic [PW-1:0] sync_lim;
	logic [W2-1:0] d2, d3, p2, p3;
	logic [W4-1:0] d10, p10;
	logic          is_zero, is_one;
	logic [CW-1:0] bc;
	logic [CW-1:0] bc_m1;
	logic [CW-1:0] idx_full;
	logic [7:0]    sh;
	logic          step;

	always_comb begin
		if (cfg.frame_bytes == 5'd0)
			frame_len = 5'd1;
		else if (cfg.frame_bytes > MAX_FB)
			frame_len = MAX_FB;
		else
			frame_len = cfg.frame_bytes;
	end

	assign total    = CW'({frame_len, 3'b000});
	assign sync_lim = PW'({1'b0, cfg.preamble_ratio} + 9'd1) * PW'(last_q);

	assign d2  = W2'({dur_s1, 1'b0});
	assign d3  = W2'(dur_s1) + d2;
	assign p2  = W2'({last_q, 1'b0});
	assign p3  = W2'(last_q) + p2;
	assign d10 = W4'({dur_s1, 3'b000}) + W4'({dur_s1, 1'b0});
	assign p10 = W4'({last_q, 3'b000}) + W4'({last_q, 1'b0});

	assign is_zero = (dur_s1 != '0) && (last_q != '0) && (d2 >= p3) && (W4'(dur_s1) <= p10);
	assign is_one  = (dur_s1 != '0) && (last_q != '0) && (p2 >= d3) && (W4'(last_q) <= d10);

	always_comb begin
		locked_n     = locked_q;
		last_n       = last_q;
		bit_count_n  = bit_count_q;
		byte_shift_n = byte_shift_q;
		res          = '0;
		res.status   = prfd_pkg::STATUS_CONTINUE;
		bc           = bit_count_q;
		bc_m1        = '0;
		idx_full     = '0;
		sh           = byte_shift_q;
		if (!locked_q) begin
			if (last_q == '0) begin
				if (level_s1)
					last_n = dur_s1;
			end else begin
				if (!level_s1 && (PW'(dur_s1) >= sync_lim))
					locked_n = 1'b1;
				last_n = dur_s1;
			end
		end else if (level_s1) begin
			last_n = dur_s1;
		end else if (!(is_zero || is_one)) begin
			locked_n     = 1'b0;
			last_n       = '0;
			bit_count_n  = '0;
			byte_shift_n = '0;
			res.status   = prfd_pkg::STATUS_RESTART;
		end else begin
			res.bit_valid = 1'b1;
			res.bit_value = ~is_zero;
			if (bc < total) begin
				sh = {sh[6:0], ~is_zero};
				bc = bc + 1'b1;
				if (bc[2:0] == 3'd0) begin
					bc_m1          = bc - 1'b1;
					idx_full       = bc_m1 >> 3;
					res.byte_valid = 1'b1;
					res.byte_value = sh;
					res.byte_index = 4'(idx_full);
					sh             = 8'd0;
				end
			end
			last_n = dur_s1;
			if (bc >= total) begin
				bc         = '0;
				sh         = 8'd0;
				res.status = prfd_pkg::STATUS_DONE;
			end
			bit_count_n  = bc;
			byte_shift_n = sh;
		end
	end

	assign step = adv & valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			level_s1 <= in_level;
			dur_s1   <= DW'(in_duration);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q     <= 1'b0;
			last_q       <= '0;
			bit_count_q  <= '0;
			byte_shift_q <= 8'd0;
		end else if (step) begin
			locked_q     <= locked_n;
			last_q       <= last_n;
			bit_count_q  <= bit_count_n;
			byte_shift_q <= byte_shift_n;
		end
	end

endmodule

// ----- design/prfd_outreg.sv -----
// Result register on the master side.
module prfd_outreg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  prfd_pkg::result_t   res,
	input  logic                m_tready,
	output logic                adv,
	output logic                m_tvalid,
	output logic [23:0]         m_tdata
);

	logic              valid_s2;
	prfd_pkg::result_t res_s2;

	assign adv = ~valid_s2 | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2};

endmodule

// ----- design/pulse_ratio_frame_decoder.sv -----
// Top level: pulse ratio frame decoder with APB-style configuration port.
// Takes one pulse (level, duration) per beat and returns one result beat per pulse. A pulse
// can be accepted every cycle unless m_tready holds back a waiting result; an input register
// feeds the result register, with the preamble multiply-compare (9 x duration width) and the
// constant-multiple bit tests in the single logic stage between them. The slave side keeps
// accepting while a result waits, as long as the input register is free. frame_bytes
// (addr 0x0) sets bytes per frame, preamble_ratio (addr 0x4) sets the sync low multiple.
module pulse_ratio_frame_decoder #(
	parameter int MAX_FRAME_BYTES = 16,
	parameter int DURATION_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] pulse_duration
	input  logic [0:0]  s_tuser,   // [0] pulse_level
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [1:0] status, [2] bit_valid, [3] bit_value,
	                               // [4] byte_valid, [12:5] byte_value, [16:13] byte_index
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	prfd_pkg::cfg_t    cfg;
	prfd_pkg::result_t res;
	logic              valid_s1;
	logic              adv;
	logic              in_take;

	assign s_tready = ~valid_s1 | adv;
	assign in_take  = s_tvalid & s_tready;

	prfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	prfd_core #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES),
		.DURATION_BITS   (DURATION_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_take     (in_take),
		.in_level    (s_tuser[0]),
		.in_duration (s_tdata),
		.adv         (adv),
		.cfg         (cfg),
		.valid_s1    (valid_s1),
		.res         (res)
	);

	prfd_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res      (res),
		.m_tready (m_tready),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	// input side only stalls when both registers are full
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && valid_s1))
		else $error("input stalled with a free register");

	a_byte_needs_bit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[2])
		else $error("byte beat without a decoded bit");

	a_restart_no_bit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == prfd_pkg::STATUS_RESTART) |-> !m_tdata[2] && !m_tdata[4])
		else $error("restart beat carries a bit");

	a_unused_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:17] == 7'd0) && (m_tdata[1:0] != 2'd3))
		else $error("bad result encoding");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top: streams pulses into the frame decoder and checks every result beat.
module tb_top;

	localparam int RUN_LIMIT       = 400000;
	localparam int HOLD_CYCLES     = 300;
	localparam int FRAME_BYTES_MAX = 16;
	localparam int PHASE_PULSES    = 200;

	localparam prfd_pkg::result_t RES_NONE = '{byte_index: 4'd0, byte_value: 8'd0,
		byte_valid: 1'b0, bit_value: 1'b0, bit_valid: 1'b0,
		status: prfd_pkg::STATUS_CONTINUE};
	localparam prfd_pkg::result_t RES_RESTART = '{byte_index: 4'd0, byte_value: 8'd0,
		byte_valid: 1'b0, bit_value: 1'b0, bit_valid: 1'b0,
		status: prfd_pkg::STATUS_RESTART};

	typedef struct packed {
		logic              lvl;
		logic [15:0]       dur;
		logic              typed;
		prfd_pkg::result_t res;
	} pulse_row_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_SLOW} rx_mode_t;

	// typed = 0: expectation comes from decode_pulse
	localparam pulse_row_t DIR_ROWS [27] = '{
		'{1'b0, 16'd100,   1'b1, RES_NONE},     // low with no previous pulse: ignored
		'{1'b1, 16'd0,     1'b1, RES_NONE},
		'{1'b1, 16'd100,   1'b1, RES_NONE},
		'{1'b0, 16'd2599,  1'b1, RES_NONE},     // one tick short of sync
		'{1'b1, 16'd100,   1'b1, RES_NONE},
		'{1'b0, 16'd2600,  1'b1, RES_NONE},     // sync
		'{1'b1, 16'd100,   1'b1, RES_NONE},
		'{1'b0, 16'd150,   1'b0, RES_NONE},     // zero bit, 1.5x edge
		'{1'b1, 16'd100,   1'b1, RES_NONE},
		'{1'b0, 16'd1000,  1'b0, RES_NONE},     // zero bit, 10x edge
		'{1'b1, 16'd150,   1'b1, RES_NONE},
		'{1'b0, 16'd100,   1'b0, RES_NONE},     // one bit, 1.5x edge
		'{1'b1, 16'd1000,  1'b1, RES_NONE},
		'{1'b0, 16'd100,   1'b0, RES_NONE},     // one bit, 10x edge
		'{1'b1, 16'd100,   1'b1, RES_NONE},
		'{1'b0, 16'd149,   1'b1, RES_RESTART},
		'{1'b1, 16'd1,     1'b1, RES_NONE},
		'{1'b0, 16'd65535, 1'b1, RES_NONE},
		'{1'b1, 16'd100,   1'b1, RES_NONE},
		'{1'b0, 16'd1001,  1'b1, RES_RESTART},
		'{1'b1, 16'd1,     1'b1, RES_NONE},
		'{1'b0, 16'd26,    1'b1, RES_NONE},
		'{1'b0, 16'd0,     1'b1, RES_RESTART},  // zero low while locked
		'{1'b1, 16'd1,     1'b1, RES_NONE},
		'{1'b0, 16'd30,    1'b1, RES_NONE},
		'{1'b1, 16'd0,     1'b1, RES_NONE},
		'{1'b0, 16'd5,     1'b1, RES_RESTART}   // zero previous width
	};

	localparam int PH_FRAME [6] = '{1, 16, 0, 31, 5, -1};
	localparam int PH_RATIO [6] = '{0, 255, 1, 25, 7, -1};
	localparam int PH_GAP   [6] = '{0, 8, 4, 12, 0, 6};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;    // [15:0] pulse_duration
	logic [0:0]  s_tuser  = '0;    // [0] pulse_level
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // [1:0] status, [2] bit_valid, [3] bit_value,
	                               // [4] byte_valid, [12:5] byte_value, [16:13] byte_index
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	pulse_ratio_frame_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// decoder state and register copies
	logic       frame_locked    = 1'b0;
	logic [15:0] prev_width     = '0;
	logic [7:0] bit_cnt         = '0;
	logic [7:0] shift_reg       = '0;
	logic [4:0] cfg_frame_bytes = prfd_pkg::FRAME_BYTES_RST;
	logic [7:0] cfg_ratio       = prfd_pkg::PREAMBLE_RATIO_RST;

	prfd_pkg::result_t pending_results[$];
	int      fails       = 0;
	int      pulses_sent = 0;
	int      burst_left  = 0;
	int      gap_max     = 0;
	bit      offering    = 1'b0;
	bit      hold_req    = 1'b0;

	function automatic int frame_len();
		if (cfg_frame_bytes == 0)
			return 1;
		if (cfg_frame_bytes > FRAME_BYTES_MAX)
			return FRAME_BYTES_MAX;
		return cfg_frame_bytes;
	endfunction

	function automatic prfd_pkg::result_t decode_pulse(input logic lvl, input logic [15:0] dur);
		prfd_pkg::result_t r;
		int      d;
		int      p;
		logic    good;
		logic    bitv;
		r = RES_NONE;
		d = dur;
		p = prev_width;
		good = 1'b0;
		bitv = 1'b0;
		if (!frame_locked) begin
			if (p == 0) begin
				if (lvl)
					prev_width = dur;
			end else begin
				if (!lvl && d >= (int'(cfg_ratio) + 1) * p)
					frame_locked = 1'b1;
				prev_width = dur;
			end
		end else if (lvl) begin
			prev_width = dur;
		end else begin
			if (d != 0 && p != 0 && 2 * d >= 3 * p && d <= 10 * p) begin
				good = 1'b1;
			end else if (d != 0 && p != 0 && 2 * p >= 3 * d && p <= 10 * d) begin
				good = 1'b1;
				bitv = 1'b1;
			end else begin
				frame_locked = 1'b0;
				prev_width = '0;
				bit_cnt = '0;
				shift_reg = '0;
				r.status = prfd_pkg::STATUS_RESTART;
			end
			if (good) begin
				r.bit_valid = 1'b1;
				r.bit_value = bitv;
				if (bit_cnt < frame_len() * 8) begin
					shift_reg = {shift_reg[6:0], bitv};
					bit_cnt = bit_cnt + 8'd1;
					if (bit_cnt[2:0] == 3'd0) begin
						r.byte_valid = 1'b1;
						r.byte_value = shift_reg;
						r.byte_index = 4'((bit_cnt - 8'd1) >> 3);
						shift_reg = '0;
					end
				end
				prev_width = dur;
				if (bit_cnt >= frame_len() * 8) begin
					bit_cnt = '0;
					shift_reg = '0;
					r.status = prfd_pkg::STATUS_DONE;
				end
			end
		end
		return r;
	endfunction

	function automatic int rand_width(input int maxv);
		int cap;
		cap = (1 << $urandom_range(1, 16)) - 1;
		if (cap > maxv)
			cap = maxv;
		return $urandom_range(1, cap);
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	task automatic lower_valid();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	task automatic send_pulse(input logic lvl, input logic [15:0] dur, input logic typed,
	                          input prfd_pkg::result_t res);
		prfd_pkg::result_t want;
		s_tvalid <= 1'b1;
		s_tuser  <= lvl;
		s_tdata  <= dur;
		offering = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = decode_pulse(lvl, dur);
		pending_results.push_back(typed ? res : want);
		pulses_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			if (gap_max > 0) begin
				lower_valid();
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		lower_valid();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input prfd_pkg::reg_idx_t idx,
	                          input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input prfd_pkg::reg_idx_t idx, input logic [31:0] want);
		logic [31:0] rdata;
		apb_access(1'b0, idx, '0, rdata);
		if (rdata !== want) begin
			$error("%s readback: expected %0h, got %0h", idx.name(), want, rdata);
			fails++;
		end
	endtask

	task automatic set_reg(input prfd_pkg::reg_idx_t idx, input logic [7:0] value);
		logic [31:0] wdata;
		logic [31:0] rdata;
		wdata = $urandom;
		if (idx == prfd_pkg::REG_FRAME_BYTES) begin
			wdata[4:0] = value[4:0];
			cfg_frame_bytes = value[4:0];
		end else begin
			wdata[7:0] = value;
			cfg_ratio = value;
		end
		apb_access(1'b1, idx, wdata, rdata);
		check_reg(idx, (idx == prfd_pkg::REG_FRAME_BYTES) ? {27'd0, value[4:0]}
			: {24'd0, value});
	endtask

	// sync (when unlocked, else at random) then one or two frames of bit pairs; one malformed if broken
	task automatic send_frame(input bit broken);
		int   nbits;
		int   bad_at;
		int   h;
		int   l;
		logic b;
		nbits = frame_len() * 8 * ((frame_len() <= 4) ? $urandom_range(1, 2) : 1);
		bad_at = broken ? $urandom_range(0, nbits - 1) : -1;
		if (!frame_locked || $urandom_range(0, 3) == 0) begin
			h = rand_width(65535 / (int'(cfg_ratio) + 1));
			send_pulse(1'b1, 16'(h), 1'b0, RES_NONE);
			send_pulse(1'b0, 16'($urandom_range((int'(cfg_ratio) + 1) * h, 65535)), 1'b0,
				RES_NONE);
		end
		for (int i = 0; i < nbits; i++) begin
			if (i == bad_at) begin
				h = rand_width(5000);
				case ($urandom_range(0, 2))
					0: l = h;
					1: l = 10 * h + $urandom_range(1, 9);
					default: begin
						l = rand_width(65535);
						h = 0;    // low right after low
					end
				endcase
			end else begin
				b = 1'($urandom_range(0, 1));
				if (b) begin
					h = rand_width(65535);
					if (h < 2)
						h = 2;
					l = $urandom_range((h + 9) / 10, (2 * h) / 3);
				end else begin
					h = rand_width(43690);
					l = $urandom_range((3 * h + 1) / 2, (10 * h > 65535) ? 65535 : 10 * h);
				end
			end
			if (h != 0)
				send_pulse(1'b1, 16'(h), 1'b0, RES_NONE);
			send_pulse(1'b0, 16'(l), 1'b0, RES_NONE);
		end
	endtask

	initial begin
		int start;
		int sel;
		int fb;
		int ratio;
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;
		wait (arst_n);
		@(posedge clk);
		check_reg(prfd_pkg::REG_FRAME_BYTES, {27'd0, prfd_pkg::FRAME_BYTES_RST});
		check_reg(prfd_pkg::REG_PREAMBLE_RATIO, {24'd0, prfd_pkg::PREAMBLE_RATIO_RST});

		gap_max = 3;
		foreach (DIR_ROWS[i])
			send_pulse(DIR_ROWS[i].lvl, DIR_ROWS[i].dur, DIR_ROWS[i].typed, DIR_ROWS[i].res);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			fb = (PH_FRAME[ph] < 0) ? $urandom_range(0, 31) : PH_FRAME[ph];
			ratio = (PH_RATIO[ph] < 0) ? $urandom_range(0, 255) : PH_RATIO[ph];
			set_reg(prfd_pkg::REG_FRAME_BYTES, 8'(fb));
			set_reg(prfd_pkg::REG_PREAMBLE_RATIO, 8'(ratio));
			gap_max = PH_GAP[ph];
			start = pulses_sent;
			while (pulses_sent - start < PHASE_PULSES) begin
				if (ph == 1 && !held && pulses_sent - start > 40) begin
					held = 1'b1;
					hold_req = 1'b1;
				end
				if (ph == 2 && !paused && pulses_sent - start > 100) begin
					paused = 1'b1;
					wait_drained();
				end
				sel = $urandom_range(0, 99);
				if (sel < 65) begin
					send_frame(1'b0);
				end else if (sel < 80) begin
					send_frame(1'b1);
				end else begin
					repeat ($urandom_range(1, 6))
						send_pulse(1'($urandom_range(0, 1)),
							($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF)
								: 16'($urandom_range(1, 65535)),
							1'b0, RES_NONE);
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d result beats never arrived", pending_results.size());
			fails++;
		end
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// receiver: stall pattern of its own, plus one long hold on request
	initial begin
		rx_mode_t mode;
		int       tick;
		tick = 0;
		wait (arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			repeat ($urandom_range(32, 200)) begin
				@(posedge clk);
				tick++;
				if (hold_req) begin
					hold_req = 1'b0;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
					default:   m_tready <= (tick % 4 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		prfd_pkg::result_t got;
		prfd_pkg::result_t want;
		if (m_tvalid && m_tready) begin
			got = prfd_pkg::result_t'(m_tdata[16:0]);
			if (pending_results.size() == 0) begin
				$error("result beat with nothing pending: %h", m_tdata);
				fails++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", int'(want.status), int'(got.status));
				check_field("bit_valid", want.bit_valid, got.bit_valid);
				check_field("bit_value", want.bit_value, got.bit_value);
				check_field("byte_valid", want.byte_valid, got.byte_valid);
				check_field("byte_value", want.byte_value, got.byte_value);
				check_field("byte_index", want.byte_index, got.byte_index);
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
design/prfd_pkg.sv
design/prfd_cfg.sv
design/prfd_core.sv
design/prfd_outreg.sv
design/pulse_ratio_frame_decoder.sv
tb/sv/tb_top.sv
